// File: rtl/box_average_image_downscaler_core_defines.svh
// Assertion helpers shared by the downscaler RTL.
// Each macro expects aclk and aresetn in scope.
`ifndef BOX_AVERAGE_IMAGE_DOWNSCALER_CORE_DEFINES_SVH
`define BOX_AVERAGE_IMAGE_DOWNSCALER_CORE_DEFINES_SVH

// Same-cycle implication.
`define BXD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BXD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bxd_pkg.sv
package bxd_pkg;

    localparam int MAX_SOURCE_SIDE  = 4096;
    localparam int MAX_TARGET_WIDTH = 256;
    localparam int CHANNEL_BITS     = 16;

    localparam int SIDE_W  = 13;
    localparam int COORD_W = 12;
    localparam int TGT_W   = 9;
    localparam int BIN_W   = 8;
    localparam int SUM_W   = 40;
    localparam int CNT_W   = 25;
    localparam int NCHAN   = 4;

    localparam int DIV_N_W   = SUM_W + 1;
    localparam int DIV_D_W   = CNT_W;
    localparam int DIV_CNT_W = 6;

    localparam int ADDR_W = 4;

    localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_TARGET_WIDTH  = 2'd2;

    typedef enum logic [2:0] {
        ST_SETUP,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        JOB_HEIGHT,
        JOB_COL,
        JOB_ROW,
        JOB_AVG
    } job_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_N_W-1:0]   quotient;
        logic [DIV_D_W-1:0]   remainder;
    } div_status_t;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        if (v == '0) begin
            r = SIDE_W'(1);
        end else if (v > SIDE_W'(MAX_SOURCE_SIDE)) begin
            r = SIDE_W'(MAX_SOURCE_SIDE);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [TGT_W-1:0] clamp_target(input logic [TGT_W-1:0] v);
        logic [TGT_W-1:0] r;
        if (v > TGT_W'(MAX_TARGET_WIDTH)) begin
            r = TGT_W'(MAX_TARGET_WIDTH);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// File: rtl/bxd_sum_ram.sv
module bxd_sum_ram #(
    parameter int DATA_W = 160,
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/bxd_div.sv
module bxd_div
    import bxd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output div_status_t        status
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_N_W-1:0]   quo_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_D_W-1:0]   div_reg;

    logic [DIV_D_W:0]     shifted;
    logic                 ge;
    logic [DIV_D_W-1:0]   rem_next;

    // One quotient bit per cycle, restoring.
    always_comb begin
        shifted  = {rem_reg, quo_reg[DIV_N_W-1]};
        ge       = shifted >= {1'b0, div_reg};
        rem_next = ge ? DIV_D_W'(shifted - {1'b0, div_reg}) : shifted[DIV_D_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_N_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIV_N_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign status.done      = done_reg;
    assign status.quotient  = quo_reg;
    assign status.remainder = rem_reg;

endmodule

// File: rtl/box_average_image_downscaler_core.sv
// A pass-through pixel goes from acceptance through ST_READ and ST_EMIT to the output
// register; a pixel that closes a bin goes through ST_READ, four divides (one per
// channel) and ST_EMIT. A new pixel is taken only in ST_IDLE, after the last one is
// through; the pace is set by the sum-line read-modify-write and the shared divider.
// Reset (aresetn low, synchronous): registers return to 1/1/160. Reset, each write to a
// defined register and each frame end run a frame setup; scaling adds three divides.
`include "box_average_image_downscaler_core_defines.svh"

module box_average_image_downscaler_core
    import bxd_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,

    // configuration port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,

    // source pixels
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [CHANNEL_BITS-1:0] s_in_red,
    input  logic [CHANNEL_BITS-1:0] s_in_green,
    input  logic [CHANNEL_BITS-1:0] s_in_blue,
    input  logic [CHANNEL_BITS-1:0] s_in_alpha,

    // result pixels
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [CHANNEL_BITS-1:0] m_out_red,
    output logic [CHANNEL_BITS-1:0] m_out_green,
    output logic [CHANNEL_BITS-1:0] m_out_blue,
    output logic [CHANNEL_BITS-1:0] m_out_alpha,
    output logic [COORD_W-1:0]      m_out_column,
    output logic [COORD_W-1:0]      m_out_row,
    output logic                    m_frame_done
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SIDE_W-1:0] src_w_reg;
    logic [SIDE_W-1:0] src_h_reg;
    logic [TGT_W-1:0]  tgt_w_reg;

    logic [1:0] cfg_index;
    logic       cfg_write;
    logic       cfg_hit;

    assign pready    = 1'b1;
    assign cfg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;
    // Only the three defined registers restart the frame.
    assign cfg_hit   = cfg_write && (cfg_index == REG_SOURCE_WIDTH ||
                                     cfg_index == REG_SOURCE_HEIGHT ||
                                     cfg_index == REG_TARGET_WIDTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg <= SIDE_W'(1);
            src_h_reg <= SIDE_W'(1);
            tgt_w_reg <= TGT_W'(160);
        end else if (cfg_write) begin
            case (cfg_index)
                REG_SOURCE_WIDTH:  src_w_reg <= pwdata[SIDE_W-1:0];
                REG_SOURCE_HEIGHT: src_h_reg <= pwdata[SIDE_W-1:0];
                REG_TARGET_WIDTH:  tgt_w_reg <= pwdata[TGT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_SOURCE_WIDTH:  prdata = 32'(src_w_reg);
            REG_SOURCE_HEIGHT: prdata = 32'(src_h_reg);
            REG_TARGET_WIDTH:  prdata = 32'(tgt_w_reg);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Frame geometry and position tracking
    // ------------------------------------------------------------------
    state_t state_reg, state_next;
    job_t   job_reg;
    logic [1:0] chan_reg;

    logic [SIDE_W-1:0]  eff_w_reg, eff_h_reg;
    logic [TGT_W-1:0]   eff_t_reg;
    logic               pass_reg;
    logic [SIDE_W-1:0]  rh_reg;
    logic [SIDE_W-1:0]  col_q_reg, row_q_reg;
    logic [TGT_W-1:0]   col_r_reg, col_acc_reg;
    logic [SIDE_W-1:0]  row_r_reg, row_acc_reg;

    logic [COORD_W-1:0] src_col_reg, src_row_reg, band_row_reg;
    logic [BIN_W-1:0]   bin_reg;
    logic [SIDE_W-1:0]  col_start_reg, col_edge_reg, band_start_reg, band_edge_reg;

    // pixel, sums and pending result
    logic [CHANNEL_BITS-1:0] pix_reg [NCHAN];
    logic [SUM_W-1:0]        sum_reg [NCHAN];
    logic [CHANNEL_BITS-1:0] res_reg [NCHAN];
    logic [CNT_W-1:0]        count_reg;
    logic [COORD_W-1:0]      pend_col_reg, pend_row_reg;
    logic                    pend_done_reg, frame_end_reg;

    // output register
    logic                    m_valid_reg;
    logic [CHANNEL_BITS-1:0] out_chan_reg [NCHAN];
    logic [COORD_W-1:0]      out_col_reg, out_row_reg;
    logic                    out_done_reg;

    // control
    logic accept, mem_rd_en, mem_wr_en, div_start, out_load;

    // setup values from the registers
    logic [SIDE_W-1:0] set_w, set_h;
    logic [TGT_W-1:0]  set_t;
    logic              set_pass;

    always_comb begin
        set_w    = clamp_side(src_w_reg);
        set_h    = clamp_side(src_h_reg);
        set_t    = clamp_target(tgt_w_reg);
        set_pass = (set_t == '0) || (SIDE_W'(set_t) >= set_w);
    end

    // ------------------------------------------------------------------
    // Sum line memory: one 160-bit word of four channel sums per bin
    // ------------------------------------------------------------------
    logic [NCHAN*SUM_W-1:0] mem_rd_data, mem_wr_data;
    logic [SUM_W-1:0]       new_sum [NCHAN];

    bxd_sum_ram #(
        .DATA_W (NCHAN * SUM_W),
        .ADDR_W (BIN_W)
    ) u_sum_ram (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (bin_reg),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (bin_reg),
        .rd_data (mem_rd_data)
    );

    // ------------------------------------------------------------------
    // Shared divider
    // ------------------------------------------------------------------
    logic [DIV_N_W-1:0] div_dividend;
    logic [DIV_D_W-1:0] div_divisor;
    div_status_t        div_st;

    bxd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .status   (div_st)
    );

    always_comb begin
        case (job_reg)
            JOB_HEIGHT: begin
                // round(H*w/W) = (2*H*w + W) / (2*W)
                div_dividend = DIV_N_W'({(SIDE_W + TGT_W)'(eff_h_reg) *
                                         (SIDE_W + TGT_W)'(eff_t_reg), 1'b0})
                             + DIV_N_W'(eff_w_reg);
                div_divisor  = DIV_D_W'({eff_w_reg, 1'b0});
            end
            JOB_COL: begin
                div_dividend = DIV_N_W'(eff_w_reg);
                div_divisor  = DIV_D_W'(eff_t_reg);
            end
            JOB_ROW: begin
                div_dividend = DIV_N_W'(eff_h_reg);
                div_divisor  = DIV_D_W'(rh_reg);
            end
            JOB_AVG: begin
                div_dividend = DIV_N_W'(sum_reg[chan_reg]) + DIV_N_W'(count_reg >> 1);
                div_divisor  = count_reg;
            end
            default: begin
                div_dividend = '0;
                div_divisor  = DIV_D_W'(1);
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Per-pixel decisions, valid in ST_READ
    // ------------------------------------------------------------------
    logic              last_col, last_row, band_last, first_of_bin, col_hit, emit_avg;
    logic [TGT_W-1:0]  bin_inc;
    logic              bin_wrap;
    logic [TGT_W:0]    col_acc_sum;
    logic              col_carry;
    logic [SIDE_W:0]   row_acc_sum;
    logic              row_carry;
    logic              done_avg;

    always_comb begin
        last_col     = (SIDE_W'(src_col_reg) + 1'b1) >= eff_w_reg;
        last_row     = (SIDE_W'(src_row_reg) + 1'b1) >= eff_h_reg;
        band_last    = (SIDE_W'(src_row_reg) + 1'b1) == band_edge_reg;
        first_of_bin = (SIDE_W'(src_row_reg) == band_start_reg) &&
                       (SIDE_W'(src_col_reg) == col_start_reg);
        col_hit      = (SIDE_W'(src_col_reg) + 1'b1) == col_edge_reg;
        emit_avg     = !pass_reg && col_hit && band_last;
        bin_inc      = TGT_W'(bin_reg) + 1'b1;
        bin_wrap     = bin_inc >= eff_t_reg;
        col_acc_sum  = (TGT_W + 1)'(col_acc_reg) + (TGT_W + 1)'(col_r_reg);
        col_carry    = col_acc_sum >= (TGT_W + 1)'(eff_t_reg);
        row_acc_sum  = (SIDE_W + 1)'(row_acc_reg) + (SIDE_W + 1)'(row_r_reg);
        row_carry    = row_acc_sum >= (SIDE_W + 1)'(rh_reg);
        done_avg     = (bin_inc == eff_t_reg) &&
                       ((SIDE_W'(band_row_reg) + 1'b1) == rh_reg);
        for (int c = 0; c < NCHAN; c++) begin
            new_sum[c] = first_of_bin ? SUM_W'(pix_reg[c])
                       : mem_rd_data[c*SUM_W +: SUM_W] + SUM_W'(pix_reg[c]);
        end
        mem_wr_data = {new_sum[3], new_sum[2], new_sum[1], new_sum[0]};
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_SETUP: begin
                state_next = set_pass ? ST_IDLE : ST_DIV_START;
            end
            ST_DIV_START: begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_st.done) begin
                    case (job_reg)
                        JOB_ROW: state_next = ST_IDLE;
                        JOB_AVG: state_next = (chan_reg == 2'd3) ? ST_EMIT : ST_DIV_START;
                        default: state_next = ST_DIV_START;
                    endcase
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (pass_reg) begin
                    state_next = ST_EMIT;
                end else if (emit_avg) begin
                    state_next = ST_DIV_START;
                end else if (last_col && last_row) begin
                    state_next = ST_SETUP;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    state_next = frame_end_reg ? ST_SETUP : ST_IDLE;
                end
            end
            default: state_next = ST_SETUP;
        endcase
        // a write to a defined register restarts the frame
        if (cfg_hit) begin
            state_next = ST_SETUP;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: control outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        accept    = s_valid && s_ready;
        mem_rd_en = accept;
        mem_wr_en = (state_reg == ST_READ) && !pass_reg;
        div_start = (state_reg == ST_DIV_START);
        out_load  = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SETUP;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Geometry and position registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_reg        <= JOB_HEIGHT;
            chan_reg       <= '0;
            src_col_reg    <= '0;
            src_row_reg    <= '0;
            bin_reg        <= '0;
            band_row_reg   <= '0;
            col_start_reg  <= '0;
            band_start_reg <= '0;
            frame_end_reg  <= 1'b0;
        end else begin
            case (state_reg)
                ST_SETUP: begin
                    // start over at source pixel (0,0)
                    eff_w_reg      <= set_w;
                    eff_h_reg      <= set_h;
                    eff_t_reg      <= set_t;
                    pass_reg       <= set_pass;
                    src_col_reg    <= '0;
                    src_row_reg    <= '0;
                    bin_reg        <= '0;
                    band_row_reg   <= '0;
                    col_start_reg  <= '0;
                    band_start_reg <= '0;
                    frame_end_reg  <= 1'b0;
                    job_reg        <= JOB_HEIGHT;
                    rh_reg         <= set_h;
                    col_edge_reg   <= SIDE_W'(1);
                    band_edge_reg  <= SIDE_W'(1);
                end
                ST_DIV_WAIT: begin
                    if (div_st.done) begin
                        case (job_reg)
                            JOB_HEIGHT: begin
                                rh_reg  <= (div_st.quotient == '0) ? SIDE_W'(1)
                                         : div_st.quotient[SIDE_W-1:0];
                                job_reg <= JOB_COL;
                            end
                            JOB_COL: begin
                                col_q_reg    <= div_st.quotient[SIDE_W-1:0];
                                col_r_reg    <= div_st.remainder[TGT_W-1:0];
                                col_edge_reg <= div_st.quotient[SIDE_W-1:0];
                                col_acc_reg  <= div_st.remainder[TGT_W-1:0];
                                job_reg      <= JOB_ROW;
                            end
                            JOB_ROW: begin
                                row_q_reg     <= div_st.quotient[SIDE_W-1:0];
                                row_r_reg     <= div_st.remainder[SIDE_W-1:0];
                                band_edge_reg <= div_st.quotient[SIDE_W-1:0];
                                row_acc_reg   <= div_st.remainder[SIDE_W-1:0];
                            end
                            JOB_AVG: begin
                                chan_reg <= chan_reg + 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_READ: begin
                    if (!pass_reg) begin
                        // close the column bin: advance to the next edge; the last
                        // bin of a row always ends on the last column and wraps
                        if (col_hit) begin
                            if (bin_wrap) begin
                                bin_reg       <= '0;
                                col_start_reg <= '0;
                                col_edge_reg  <= col_q_reg;
                                col_acc_reg   <= col_r_reg;
                            end else begin
                                bin_reg       <= bin_inc[BIN_W-1:0];
                                col_start_reg <= col_edge_reg;
                                col_edge_reg  <= col_edge_reg + col_q_reg + SIDE_W'(col_carry);
                                col_acc_reg   <= col_carry
                                               ? TGT_W'(col_acc_sum - (TGT_W + 1)'(eff_t_reg))
                                               : col_acc_sum[TGT_W-1:0];
                            end
                        end
                        // close the band at the end of its last row
                        if (last_col && band_last) begin
                            band_row_reg   <= band_row_reg + 1'b1;
                            band_start_reg <= band_edge_reg;
                            band_edge_reg  <= band_edge_reg + row_q_reg + SIDE_W'(row_carry);
                            row_acc_reg    <= row_carry
                                            ? SIDE_W'(row_acc_sum - (SIDE_W + 1)'(rh_reg))
                                            : row_acc_sum[SIDE_W-1:0];
                        end
                    end
                    if (last_col) begin
                        if (last_row) begin
                            frame_end_reg <= 1'b1;
                        end else begin
                            src_col_reg <= '0;
                            src_row_reg <= src_row_reg + 1'b1;
                        end
                    end else begin
                        src_col_reg <= src_col_reg + 1'b1;
                    end
                    if (emit_avg) begin
                        job_reg  <= JOB_AVG;
                        chan_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pixel capture and pending result
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_reg[0] <= s_in_red;
            pix_reg[1] <= s_in_green;
            pix_reg[2] <= s_in_blue;
            pix_reg[3] <= s_in_alpha;
        end
        if (state_reg == ST_DIV_WAIT && div_st.done && job_reg == JOB_AVG) begin
            res_reg[chan_reg] <= div_st.quotient[CHANNEL_BITS-1:0];
        end
        if (state_reg == ST_READ) begin
            sum_reg   <= new_sum;
            count_reg <= CNT_W'(col_edge_reg - col_start_reg) *
                         CNT_W'(band_edge_reg - band_start_reg);
            if (pass_reg) begin
                res_reg       <= pix_reg;
                pend_col_reg  <= src_col_reg;
                pend_row_reg  <= src_row_reg;
                pend_done_reg <= last_col && last_row;
            end else begin
                pend_col_reg  <= COORD_W'(bin_reg);
                pend_row_reg  <= band_row_reg;
                pend_done_reg <= done_avg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_chan_reg <= res_reg;
            out_col_reg  <= pend_col_reg;
            out_row_reg  <= pend_row_reg;
            out_done_reg <= pend_done_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_red    = out_chan_reg[0];
    assign m_out_green  = out_chan_reg[1];
    assign m_out_blue   = out_chan_reg[2];
    assign m_out_alpha  = out_chan_reg[3];
    assign m_out_column = out_col_reg;
    assign m_out_row    = out_row_reg;
    assign m_frame_done = out_done_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `BXD_ASSERT_NEXT(a_accept_reads, accept && !cfg_hit, state_reg == ST_READ, "accept not followed by read")
    `BXD_ASSERT_NOW(a_wr_not_pass, mem_wr_en, !pass_reg && state_reg == ST_READ, "sum write in pass mode")
    `BXD_ASSERT_NOW(a_load_free, out_load, !m_valid_reg || m_ready, "output overwritten")
    `BXD_ASSERT_NEXT(a_div_wait, div_start && !cfg_hit, state_reg == ST_DIV_WAIT, "divide start lost")

endmodule

// File: bench/downscale_checker.sv
`timescale 1ns / 1ps

module downscale_checker
    import bxd_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [31:0]             pwdata,
    input  logic                    pready,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic [CHANNEL_BITS-1:0] s_in_red,
    input  logic [CHANNEL_BITS-1:0] s_in_green,
    input  logic [CHANNEL_BITS-1:0] s_in_blue,
    input  logic [CHANNEL_BITS-1:0] s_in_alpha,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic [CHANNEL_BITS-1:0] m_out_red,
    input  logic [CHANNEL_BITS-1:0] m_out_green,
    input  logic [CHANNEL_BITS-1:0] m_out_blue,
    input  logic [CHANNEL_BITS-1:0] m_out_alpha,
    input  logic [COORD_W-1:0]      m_out_column,
    input  logic [COORD_W-1:0]      m_out_row,
    input  logic                    m_frame_done,
    output int                      fail_count,
    output int                      pending_pixels
);

    typedef struct {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
        logic [CHANNEL_BITS-1:0] alpha;
        logic [COORD_W-1:0]      column;
        logic [COORD_W-1:0]      row;
        logic                    done;
    } out_pixel_t;

    out_pixel_t expected_pixels[$];

    logic [SIDE_W-1:0] cfg_src_w, cfg_src_h;
    logic [TGT_W-1:0]  cfg_tgt_w;

    logic [SUM_W-1:0] acc_line[NCHAN][MAX_TARGET_WIDTH];
    int unsigned src_col, src_row, bin_col, band_idx;
    int unsigned col_edge, band_lo, band_hi, out_height;
    int unsigned width_eff, height_eff, target_eff;
    bit          passthru;

    function automatic int unsigned limit_side(int unsigned v);
        if (v == 0) return 1;
        if (v > MAX_SOURCE_SIDE) return MAX_SOURCE_SIDE;
        return v;
    endfunction

    function automatic logic [CHANNEL_BITS-1:0] round_avg(logic [SUM_W-1:0] s,
                                                          longint unsigned n);
        longint unsigned q;
        q = (longint'(s) + n / 2) / n;
        return q[CHANNEL_BITS-1:0];
    endfunction

    task automatic begin_frame();
        width_eff  = limit_side(cfg_src_w);
        height_eff = limit_side(cfg_src_h);
        target_eff = (cfg_tgt_w > MAX_TARGET_WIDTH) ? MAX_TARGET_WIDTH : cfg_tgt_w;
        passthru   = (target_eff == 0) || (target_eff >= width_eff);
        src_col = 0; src_row = 0; bin_col = 0; band_idx = 0; band_lo = 0;
        if (passthru) begin
            out_height = height_eff;
            col_edge = 1;
            band_hi = 1;
        end else begin
            out_height = (2 * height_eff * target_eff + width_eff) / (2 * width_eff);
            if (out_height == 0) out_height = 1;
            col_edge = width_eff / target_eff;
            band_hi = height_eff / out_height;
        end
    endtask

    // Advance the shadow downscaler by one source pixel; queue any output.
    task automatic predict_pixel(logic [CHANNEL_BITS-1:0] px[NCHAN]);
        bit last_col, last_row, band_last;
        int unsigned bi, col_lo;
        longint unsigned n;
        out_pixel_t o;
        last_col = (src_col + 1 >= width_eff);
        last_row = (src_row + 1 >= height_eff);
        if (passthru) begin
            o.red = px[0]; o.green = px[1]; o.blue = px[2]; o.alpha = px[3];
            o.column = src_col[COORD_W-1:0];
            o.row    = src_row[COORD_W-1:0];
            o.done   = last_col && last_row;
            expected_pixels.insert(expected_pixels.size(), o);
        end else begin
            bi = (bin_col < MAX_TARGET_WIDTH) ? bin_col : MAX_TARGET_WIDTH - 1;
            col_lo = (bin_col * width_eff) / target_eff;
            band_last = (src_row + 1 == band_hi);
            for (int c = 0; c < NCHAN; c++) begin
                if (src_row == band_lo && src_col == col_lo) acc_line[c][bi] = px[c];
                else acc_line[c][bi] = acc_line[c][bi] + px[c];
            end
            if (src_col + 1 == col_edge) begin
                if (band_last) begin
                    n = longint'(col_edge - col_lo) * longint'(band_hi - band_lo);
                    if (n == 0) n = 1;
                    o.red    = round_avg(acc_line[0][bi], n);
                    o.green  = round_avg(acc_line[1][bi], n);
                    o.blue   = round_avg(acc_line[2][bi], n);
                    o.alpha  = round_avg(acc_line[3][bi], n);
                    o.column = bin_col[COORD_W-1:0];
                    o.row    = band_idx[COORD_W-1:0];
                    o.done   = (bin_col + 1 == target_eff) && (band_idx + 1 == out_height);
                    expected_pixels.insert(expected_pixels.size(), o);
                end
                bin_col++;
                if (bin_col >= target_eff) bin_col = 0;
                col_edge = ((bin_col + 1) * width_eff) / target_eff;
            end
            if (last_col && band_last) begin
                band_idx++;
                band_lo = band_hi;
                band_hi = ((band_idx + 1) * height_eff) / out_height;
            end
        end
        if (last_col) begin
            if (last_row) begin
                begin_frame();
            end else begin
                src_col = 0;
                src_row++;
                if (!passthru) begin
                    bin_col = 0;
                    col_edge = width_eff / target_eff;
                end
            end
        end else begin
            src_col++;
        end
    endtask

    initial begin
        fail_count = 0;
        pending_pixels = 0;
    end

    always @(posedge aclk) begin
        logic [CHANNEL_BITS-1:0] px[NCHAN];
        out_pixel_t e;
        if (!aresetn) begin
            cfg_src_w = 1; cfg_src_h = 1; cfg_tgt_w = 160;
            for (int c = 0; c < NCHAN; c++)
                for (int i = 0; i < MAX_TARGET_WIDTH; i++) acc_line[c][i] = '0;
            expected_pixels.delete();
            begin_frame();
        end else begin
            // write to a defined register: store and restart the frame
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_SOURCE_WIDTH: cfg_src_w = pwdata[SIDE_W-1:0];
                    REG_SOURCE_HEIGHT: cfg_src_h = pwdata[SIDE_W-1:0];
                    REG_TARGET_WIDTH: cfg_tgt_w = pwdata[TGT_W-1:0];
                    default: ;
                endcase
                if (paddr[3:2] == REG_SOURCE_WIDTH || paddr[3:2] == REG_SOURCE_HEIGHT ||
                    paddr[3:2] == REG_TARGET_WIDTH) begin_frame();
            end
            if (s_valid && s_ready) begin
                px[0] = s_in_red; px[1] = s_in_green; px[2] = s_in_blue; px[3] = s_in_alpha;
                predict_pixel(px);
            end
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected output pixel col %0d row %0d", $time,
                             m_out_column, m_out_row);
                    fail_count++;
                end else begin
                    e = expected_pixels.pop_front();
                    if ({e.red, e.green, e.blue, e.alpha, e.column, e.row, e.done} !==
                        {m_out_red, m_out_green, m_out_blue, m_out_alpha,
                         m_out_column, m_out_row, m_frame_done}) begin
                        $display("%0t: mismatch exp r%h g%h b%h a%h c%0d r%0d d%0b", $time,
                                 e.red, e.green, e.blue, e.alpha, e.column, e.row, e.done);
                        $display("%0t:          got r%h g%h b%h a%h c%0d r%0d d%0b", $time,
                                 m_out_red, m_out_green, m_out_blue, m_out_alpha,
                                 m_out_column, m_out_row, m_frame_done);
                        fail_count++;
                    end
                end
            end
        end
        pending_pixels = expected_pixels.size();
    end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import bxd_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [CHANNEL_BITS-1:0] s_in_red = '0, s_in_green = '0, s_in_blue = '0, s_in_alpha = '0;

    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [CHANNEL_BITS-1:0] m_out_red, m_out_green, m_out_blue, m_out_alpha;
    logic [COORD_W-1:0]      m_out_column, m_out_row;
    logic                    m_frame_done;

    int fail_count, pending_pixels;

    // idle percentages per side; the receiver process reads its own
    int  send_idle_pct = 12;
    int  recv_idle_pct = 85;
    bit  long_hold_req = 1'b0;
    int  random_pixels = 0;

    always #2 aclk = ~aclk;

    box_average_image_downscaler_core dut (.*);

    downscale_checker checker_i (.*);

    // Receiver: random back-pressure, plus one long hold-off on request.
    always @(negedge aclk) begin
        if (long_hold_req) begin
            m_ready <= 1'b0;
            repeat (3000) @(negedge aclk);
            long_hold_req = 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: count cycles in which no transaction of any kind happens.
    always @(posedge aclk) begin
        static int quiet_cycles = 0;
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet_cycles = 0;
        end else if (++quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Write one register with a setup and an access phase; we start at a negedge.
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(negedge aclk);
    endtask

    // Wait for every expected pixel, then let a bin in flight finish.
    task automatic drain();
        while (pending_pixels != 0) @(negedge aclk);
        repeat (400) @(negedge aclk);
    endtask

    task automatic configure(int w_src, int h_src, int w_tgt);
        drain();
        write_reg(REG_SOURCE_WIDTH, w_src);
        write_reg(REG_SOURCE_HEIGHT, h_src);
        write_reg(REG_TARGET_WIDTH, w_tgt);
    endtask

    // Offer one pixel; hold it until accepted. Entered and left at a negedge.
    task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b, logic [15:0] a);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_in_red <= r; s_in_green <= g; s_in_blue <= b; s_in_alpha <= a;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_channel();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_random(int count);
        repeat (count) send_pixel(pick_channel(), pick_channel(), pick_channel(),
                                  pick_channel());
        s_valid <= 1'b0;
    endtask

    initial begin
        int w_src, h_src, w_tgt, frames;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Default registers: 1x1 source, pass-through.
        send_pixel(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
        send_pixel(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
        s_valid <= 1'b0;

        // 4x2 into 2 columns: bins that mix all-ones pixels with pixels of 0 and 1 check rounding.
        configure(4, 2, 2);
        repeat (4) send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (2) send_pixel(16'h0000, 16'h0000, 16'h0001, 16'h0001);
        repeat (2) send_pixel(16'h0001, 16'h0000, 16'h0000, 16'h0001);
        s_valid <= 1'b0;

        // Target of zero, and target equal to source width: pass-through.
        configure(3, 2, 0);
        send_random(3);
        configure(3, 1, 3);
        send_random(3);

        // Zero sides clamp to one; oversized target clamps to the maximum.
        configure(0, 0, 511);
        send_random(2);
        // Oversized source width clamps to the maximum: bins 16 wide, widest target.
        configure(8191, 1, 256);
        send_random(512);
        // Tall narrow source that restarts partway through a band.
        configure(5, 4096, 1);
        send_random(12);

        // Random frames, idling profile changes by thirds.
        while (random_pixels < 1300) begin
            if (random_pixels > 866) begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end else if (random_pixels > 433) begin
                send_idle_pct = 85; recv_idle_pct = 12;
            end
            w_src = $urandom_range(1, 40);
            h_src = $urandom_range(1, 16);
            case ($urandom_range(5))
                0: w_tgt = 0;
                1: w_tgt = $urandom_range(w_src, w_src + 3);
                default: w_tgt = (w_src > 1) ? $urandom_range(1, w_src - 1) : 0;
            endcase
            frames = $urandom_range(1, 2);
            configure(w_src, h_src, w_tgt);
            send_random(w_src * h_src * frames);
            random_pixels += w_src * h_src * frames;
        end

        // Fill the block against a long receiver hold-off.
        configure(20, 10, 0);
        long_hold_req = 1'b1;
        send_random(100);
        // Pause the sender until everything is out, then resume the same frame.
        while (pending_pixels != 0) @(negedge aclk);
        send_random(100);

        while (pending_pixels != 0) @(negedge aclk);
        repeat (400) @(negedge aclk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
